@@ design/signed_int_divider_saturating_defines.svh @@
// Assertion macros used by the divider top level.
`ifndef SIGNED_INT_DIVIDER_SATURATING_DEFINES_SVH
`define SIGNED_INT_DIVIDER_SATURATING_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define SIDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divider check failed in the same cycle");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define SIDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divider check failed one cycle later");

`endif

@@ design/sids_pkg.sv @@
package sids_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture operands, strip signs, arm the step counter
      logic step;     // one restoring shift-and-subtract step
      logic finish;   // apply sign and saturation, write the output register
   } sids_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_step;   // the step counter has reached its final step
   } sids_status_type;

endpackage

@@ design/sids_ctrl.sv @@
module sids_ctrl
   import sids_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  sids_status_type status,
   output sids_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Commands follow from the state and the handshakes.
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.step   = (state_ff == ST_RUN);
      cmd.finish = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);
   end

   // Next state and next output valid.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.last_step) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and the registered output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ design/sids_datapath.sv @@
module sids_datapath
   import sids_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_WIDTH-1:0] numerator,
   input  logic [DATA_WIDTH-1:0] denominator,
   input  sids_cmd_type          cmd,
   output sids_status_type       status,
   output logic [DATA_WIDTH-1:0] quotient
);

   localparam int COUNT_W = $clog2(DATA_WIDTH);

   localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] work_ff;
   logic [DATA_WIDTH-1:0] work_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH-1:0] den_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic                  zero_ff;
   logic                  zero_in;
   logic [DATA_WIDTH-1:0] quotient_ff;
   logic [DATA_WIDTH-1:0] quotient_in;

   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   trial;
   logic                  fits;

   // Operand magnitudes; the most negative value maps onto its own bit pattern,
   // which read unsigned is exactly its magnitude.
   always_comb begin
      num_mag = numerator[DATA_WIDTH-1] ? (~numerator + ONE) : numerator;
      den_mag = denominator[DATA_WIDTH-1] ? (~denominator + ONE) : denominator;
   end

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, work_ff[DATA_WIDTH-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = !trial[DATA_WIDTH];
   end

   // Next values of the working registers.
   always_comb begin
      count_in    = count_ff;
      rem_in      = rem_ff;
      work_in     = work_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      zero_in     = zero_ff;
      quotient_in = quotient_ff;

      if (cmd.load) begin
         count_in = COUNT_W'(DATA_WIDTH - 1);
         rem_in   = '0;
         work_in  = num_mag;
         den_in   = den_mag;
         neg_in   = numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
         zero_in  = (denominator == '0);
      end

      if (cmd.step) begin
         rem_in  = fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         // Quotient bits enter at the bottom as dividend bits leave the top.
         work_in = {work_ff[DATA_WIDTH-2:0], fits};
         if (count_ff != '0) begin
            count_in = count_ff - COUNT_W'(1);
         end
      end

      // A zero divisor or an unsigned quotient above the largest positive
      // value saturates; a negative result is the plain two's complement.
      if (cmd.finish) begin
         if (zero_ff) begin
            quotient_in = MAX_POS;
         end else if (neg_ff) begin
            quotient_in = ~work_ff + ONE;
         end else if (work_ff[DATA_WIDTH-1]) begin
            quotient_in = MAX_POS;
         end else begin
            quotient_in = work_ff;
         end
      end
   end

   // The step counter is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      work_ff     <= work_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      quotient_ff <= quotient_in;
   end

   assign status.last_step = (count_ff == '0);
   assign quotient         = quotient_ff;

endmodule

@@ design/signed_int_divider_saturating.sv @@
// Signed saturating divider: an item carries a dividend and a divisor, each
// DATA_WIDTH bits of two's complement, and gives one quotient truncated toward
// zero. A zero divisor, and the most negative dividend over minus one, give the
// largest positive value. The magnitudes pass through a radix-2 restoring
// shift-and-subtract loop that yields one quotient bit per cycle. The operands
// are loaded at the accepting edge; the result becomes valid once the
// DATA_WIDTH steps and a final step that applies the sign have run, and
// the final step waits until the output register is free or being drained.
// The result sits in an output register; the block takes no new item while
// it works, and the next item can be accepted in the cycle after that
// register has been written.
module signed_int_divider_saturating
   import sids_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0 up: numerator, denominator, zero padding.
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0 up: quotient, zero padding.
   output logic [((DATA_WIDTH+7)/8)*8-1:0]          rsp_tdata
);

   localparam int RSP_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

   logic [DATA_WIDTH-1:0] numerator;
   logic [DATA_WIDTH-1:0] denominator;
   logic [DATA_WIDTH-1:0] quotient;
   sids_cmd_type          cmd;
   sids_status_type       status;

   // Unpack the operands.
   assign numerator   = req_tdata[DATA_WIDTH-1:0];
   assign denominator = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

   sids_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sids_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .numerator   (numerator),
      .denominator (denominator),
      .cmd         (cmd),
      .status      (status),
      .quotient    (quotient)
   );

   // Pack the result, zero filled to whole bytes.
   assign rsp_tdata = RSP_TDATA_W'(quotient);

`include "signed_int_divider_saturating_defines.svh"

   // Once an item is taken the block is busy on the next cycle.
   `SIDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // The output register is written only when it is free or being drained.
   `SIDS_ASSERT_NOW(a_finish_no_overwrite, clock, reset, cmd.finish, !rsp_tvalid || rsp_tready)
   // The sign is applied only once all quotient bits have been formed.
   `SIDS_ASSERT_NOW(a_finish_after_steps, clock, reset, cmd.finish, status.last_step)
   // No step runs while the block offers to take an item.
   `SIDS_ASSERT_NOW(a_step_while_busy, clock, reset, cmd.step, !req_tready)

endmodule
